// ===== rtl/erm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erm_pkg
// Types and constants shared by the echo ranging median filter.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int KIND_W     = 2;
  localparam int TS_W       = 32;
  localparam int DIST_W     = 18;
  localparam int ECHO_W     = 16;
  localparam int RANGE_W    = 10;
  localparam int SPB_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SCALE_W    = 11;
  localparam int PROD_W     = ECHO_W + SCALE_W;
  localparam int FRAC_W     = 8;

  localparam logic [SCALE_W-1:0] DIST_SCALE = 11'd1126;
  localparam logic [DIST_W-1:0]  MEDIAN_MAX = 18'd261888;

  localparam logic [KIND_W-1:0] KIND_RISE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FALL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPB       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ECHO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 2'd2;

  localparam logic [SPB_W-1:0]   SPB_RESET       = 4'd5;
  localparam logic [ECHO_W-1:0]  MAX_ECHO_RESET  = 16'd30000;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 10'd300;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int CMDQ_CW    = 3;

  typedef struct packed {
    logic              op;
    logic [DIST_W-1:0] distance;
  } cmd_t;

  typedef struct packed {
    logic [ECHO_W-1:0]  max_echo_us;
    logic [RANGE_W-1:0] max_range_cm;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/erm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erm_front
// Accepts echo events, tracks the rise time and turns each falling edge into
// a clamped distance command; timeouts pass through as commands in order.
// ----------------------------------------------------------------------------
module erm_front (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  erm_pkg::cfg_t                        cfg,
  input  wire                                  in_push,
  output logic                                 in_full,
  input  wire  [erm_pkg::KIND_W-1:0]           in_kind,
  input  wire  [erm_pkg::TS_W-1:0]             in_timestamp_us,
  input  wire  [erm_pkg::CMDQ_CW-1:0]          q_count,
  output logic                                 q_push,
  output erm_pkg::cmd_t                        q_data
);
  import erm_pkg::*;

  logic [TS_W-1:0]    rise_r;
  logic               s1_v_r;
  logic               s1_op_r;
  logic [ECHO_W-1:0]  s1_width_r;
  logic               s2_v_r;
  logic               s2_op_r;
  logic [PROD_W-1:0]  s2_prod_r;

  logic               accept;
  logic [TS_W-1:0]    width_raw;
  logic [ECHO_W-1:0]  width_clamp;
  logic [CMDQ_CW:0]   used;
  logic [DIST_W:0]    dist_raw;
  logic [DIST_W-1:0]  limit;
  logic               s1_v_nxt;
  logic               s1_op_nxt;

  assign used    = {1'b0, q_count} + (CMDQ_CW+1)'(s1_v_r) + (CMDQ_CW+1)'(s2_v_r);
  assign in_full = (used >= (CMDQ_CW+1)'(CMDQ_DEPTH));
  assign accept  = in_push && !in_full;

  assign width_raw   = in_timestamp_us - rise_r;
  assign width_clamp = (width_raw > {{(TS_W-ECHO_W){1'b0}}, cfg.max_echo_us})
                       ? cfg.max_echo_us : width_raw[ECHO_W-1:0];

  always_comb begin
    s1_v_nxt  = 1'b0;
    s1_op_nxt = OP_INSERT;
    if (accept) begin
      case (in_kind)
        KIND_FALL: begin
          s1_v_nxt  = 1'b1;
          s1_op_nxt = OP_INSERT;
        end
        KIND_TIMEOUT: begin
          s1_v_nxt  = 1'b1;
          s1_op_nxt = OP_TIMEOUT;
        end
        default: begin
          s1_v_nxt  = 1'b0;
          s1_op_nxt = OP_INSERT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept && in_kind == KIND_RISE) begin
        rise_r <= in_timestamp_us;
      end
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= s1_op_nxt;
    s1_width_r <= width_clamp;
    s2_op_r    <= s1_op_r;
    s2_prod_r  <= PROD_W'(s1_width_r) * PROD_W'(DIST_SCALE);
  end

  // distance in 1/256 cm, clamped to the range limit
  assign dist_raw = s2_prod_r[PROD_W-1:FRAC_W];
  assign limit    = {cfg.max_range_cm, {FRAC_W{1'b0}}};

  assign q_push          = s2_v_r;
  assign q_data.op       = s2_op_r;
  assign q_data.distance = (dist_raw > {1'b0, limit}) ? limit : dist_raw[DIST_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/erm_cmdq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erm_cmdq
// Short command queue between the event front end and the sorter.
// ----------------------------------------------------------------------------
module erm_cmdq (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push,
  input  erm_pkg::cmd_t                push_data,
  input  wire                          pop,
  output logic                         empty,
  output logic [erm_pkg::CMDQ_CW-1:0]  count,
  output erm_pkg::cmd_t                head
);
  import erm_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_CW-1:0] cnt_r;
  logic               do_pop;

  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/erm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erm_back
// Sorted insertion of distances, burst target tracking and result register.
// ----------------------------------------------------------------------------
module erm_back #(
  parameter int MAX_SAMPLES = 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            q_empty,
  input  erm_pkg::cmd_t                  q_head,
  output logic                           q_pop,
  input  wire                            spb_wr,
  input  wire  [erm_pkg::SPB_W-1:0]      spb_val,
  input  wire                            out_pop,
  output logic                           out_empty,
  output logic [erm_pkg::DIST_W-1:0]     out_median_distance,
  output logic                           out_no_echo
);
  import erm_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int EXT_W = (CNT_W > SPB_W) ? CNT_W : SPB_W;

  function automatic logic [CNT_W-1:0] eff_target(input logic [SPB_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e == '0) e = EXT_W'(1);
    if (e > EXT_W'(MAX_SAMPLES)) e = EXT_W'(MAX_SAMPLES);
    return CNT_W'(e);
  endfunction

  logic [DIST_W-1:0] dist_r [MAX_SAMPLES];
  logic [DIST_W-1:0] ins    [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] ge;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  tgt_r, tgt_nxt;
  logic              pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;
  logic [DIST_W-1:0] out_med_r;
  logic              out_ne_r;
  logic              take;
  logic              do_ins;
  logic              emit;
  logic [CNT_W-1:0]  tgt_half;
  // samples_per_burst as last written, used to rearm after each result
  logic [SPB_W-1:0]  spb_val_hold;

  assign take   = !q_empty && !pend_r;
  assign q_pop  = take;
  assign do_ins = take && q_head.op == OP_INSERT && cnt_r != CNT_W'(MAX_SAMPLES);
  assign emit   = pend_r && (!out_v_r || out_pop);
  assign tgt_half = tgt_r >> 1;

  // each entry keeps, takes the new value or shifts down by one
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_ins
    assign ge[i] = dist_r[i] >= q_head.distance;
    if (i == 0) begin : g_first
      always_comb begin
        if (cnt_r > CNT_W'(0) && ge[0]) begin
          ins[0] = dist_r[0];
        end else begin
          ins[0] = q_head.distance;
        end
      end
    end else begin : g_rest
      always_comb begin
        if (CNT_W'(i) < cnt_r && ge[i]) begin
          ins[i] = dist_r[i];
        end else if (CNT_W'(i) <= cnt_r) begin
          ins[i] = ge[i-1] ? q_head.distance : dist_r[i-1];
        end else begin
          ins[i] = dist_r[i];
        end
      end
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    tgt_nxt   = tgt_r;
    pend_nxt  = pend_r;
    out_v_nxt = out_v_r && !out_pop;
    if (take) begin
      if (q_head.op == OP_INSERT) begin
        if (do_ins) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        pend_nxt = (cnt_nxt >= tgt_r);
      end else begin
        if (tgt_r != '0) begin
          tgt_nxt = tgt_r - 1'b1;
        end
        pend_nxt = (cnt_r >= tgt_nxt);
      end
    end
    if (emit) begin
      out_v_nxt = 1'b1;
      pend_nxt  = 1'b0;
      cnt_nxt   = '0;
      tgt_nxt   = eff_target(spb_val_hold);
    end
    if (spb_wr) begin
      cnt_nxt = '0;
      tgt_nxt = eff_target(spb_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_val_hold <= SPB_RESET;
      cnt_r        <= '0;
      tgt_r        <= eff_target(SPB_RESET);
      pend_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (spb_wr) begin
        spb_val_hold <= spb_val;
      end
      cnt_r   <= cnt_nxt;
      tgt_r   <= tgt_nxt;
      pend_r  <= pend_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int k = 0; k < MAX_SAMPLES; k++) begin
        dist_r[k] <= ins[k];
      end
    end
    if (emit) begin
      out_ne_r  <= (tgt_r == '0);
      out_med_r <= (tgt_r == '0) ? '0 : dist_r[tgt_half[IDX_W-1:0]];
    end
  end

  assign out_empty           = !out_v_r;
  assign out_median_distance = out_med_r;
  assign out_no_echo         = out_ne_r;

endmodule
`default_nettype wire

// ===== rtl/echo_ranging_median.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// echo_ranging_median
// Median filter for an ultrasonic echo ranger: echo edges become distances,
// a burst of them is kept sorted and its median is reported.
// ----------------------------------------------------------------------------
//  channel   handshake             beat
//  in_       in_push / in_full     in_kind, in_timestamp_us
//  out_      out_pop / out_empty   out_median_distance, out_no_echo
//  cfg_      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  front: events pass registers s1 and s2 to the queue, one per cycle while
//  in_full is low; back: one command per cycle from the queue while no
//  result is pending; the event that ends a burst loads the result register
//  from the sorted store; a waiting result holds the back end once the
//  next burst ends, the queue fills, in_full rises; cfg_ready is always high
//  rst_n is synchronous and clears control state only
// ----------------------------------------------------------------------------
module echo_ranging_median #(
  parameter int MAX_SAMPLES = 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_push,
  output logic                               in_full,
  input  wire  [erm_pkg::KIND_W-1:0]         in_kind,
  input  wire  [erm_pkg::TS_W-1:0]           in_timestamp_us,
  output logic                               out_empty,
  input  wire                                out_pop,
  output logic [erm_pkg::DIST_W-1:0]         out_median_distance,
  output logic                               out_no_echo,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [erm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [erm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import erm_pkg::*;

  cfg_t               cfg_r;
  logic               cfg_we;
  logic               spb_wr;
  logic               q_push;
  cmd_t               q_data;
  logic               q_pop;
  logic               q_empty;
  logic [CMDQ_CW-1:0] q_count;
  cmd_t               q_head;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign spb_wr    = cfg_we && cfg_index == CFG_SPB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_echo_us  <= MAX_ECHO_RESET;
      cfg_r.max_range_cm <= MAX_RANGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ECHO:  cfg_r.max_echo_us  <= cfg_data[ECHO_W-1:0];
        CFG_MAX_RANGE: cfg_r.max_range_cm <= cfg_data[RANGE_W-1:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  erm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_kind         (in_kind),
    .in_timestamp_us (in_timestamp_us),
    .q_count         (q_count),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  erm_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .empty     (q_empty),
    .count     (q_count),
    .head      (q_head)
  );

  erm_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .spb_wr              (spb_wr),
    .spb_val             (cfg_data[SPB_W-1:0]),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_median_distance (out_median_distance),
    .out_no_echo         (out_no_echo)
  );

endmodule
`default_nettype wire

// ===== rtl/erm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erm_checker
// Port-level checks on the echo ranging median filter.
// ----------------------------------------------------------------------------
module erm_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_push,
  input wire                            in_full,
  input wire                            out_empty,
  input wire                            out_pop,
  input wire [erm_pkg::DIST_W-1:0]      out_median_distance,
  input wire                            out_no_echo
);
  import erm_pkg::*;

  // queues come up empty after reset
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a no-echo beat carries no distance
  a_no_echo_zero : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_no_echo |-> out_median_distance == '0)
    else $error("no-echo beat with nonzero distance");

  // distance never exceeds the largest clamp
  a_dist_range : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_median_distance <= MEDIAN_MAX)
    else $error("median distance out of range");

  // a waiting beat holds until popped
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_median_distance)
      && $stable(out_no_echo))
    else $error("result beat changed while waiting");

endmodule

bind echo_ranging_median erm_checker u_erm_checker (.*);
`default_nettype wire
